/* src/tsct_pkg.sv */
// Package for the task slot completion table: sizes, codes, entry layout
// and the count arithmetic shared by the datapath and the slot map.
// Depends on nothing.
package tsct_pkg;

   // Table geometry and count width
   localparam int NUM_SLOTS   = 64;
   localparam int FIRST_SLOT  = 8;
   localparam int COUNT_WIDTH = 16;
   localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // Beat field widths
   localparam int TYPE_W     = 2;
   localparam int ORIGIN_W   = 2;
   localparam int KIND_W     = 2;
   localparam int TOTAL_W    = 15;
   localparam int IDX_IN_W   = 6;
   localparam int STATUS_W   = 3;
   localparam int GRANT_W    = 6;
   localparam int ARR_W      = 15;
   localparam int REM_W      = 16;

   // Wide enough for every compare and difference on counts
   localparam int WIDE_W  = COUNT_WIDTH + 17;
   localparam int ENTRY_W = 4 * COUNT_WIDTH;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [SLOT_W-1:0]      slot_type;

   localparam count_type COUNT_MAX = '1;
   localparam count_type COUNT_ONE = count_type'(1);

   localparam logic [WIDE_W-1:0]        ARR_MAX_W = WIDE_W'(32767);
   localparam logic signed [WIDE_W-1:0] REM_HI_W  = WIDE_W'(32767);
   localparam logic signed [WIDE_W-1:0] REM_LO_W  = -(WIDE_W'(32768));

   // Request codes
   typedef enum logic [TYPE_W-1:0] {
      RQ_REGISTER = 2'd0,
      RQ_ARRIVAL  = 2'd1,
      RQ_LAST     = 2'd2,
      RQ_DONE     = 2'd3
   } req_op_type;

   // Origin and kind codes
   localparam logic [ORIGIN_W-1:0] ORIGIN_OTHER = 2'd3;
   localparam logic [KIND_W-1:0]   KIND_SINGLE  = 2'd0;
   localparam logic [KIND_W-1:0]   KIND_WHOLE   = 2'd1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK         = 3'd0,
      STS_NO_FREE    = 3'd1,
      STS_BAD_ORIGIN = 3'd2,
      STS_BAD_KIND   = 3'd3,
      STS_NOT_IN_USE = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic {
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   // One table entry as held in the RAM
   typedef struct packed {
      count_type worker_target;
      count_type worker_done;
      count_type tasker_target;
      count_type tasker_done;
   } entry_type;

   // Busy flag update toward the slot map
   typedef struct packed {
      logic     en;
      slot_type idx;
      logic     busy;
   } slot_upd_type;

   // Lowest free slot, from the slot map
   typedef struct packed {
      logic     found;
      slot_type slot;
   } free_info_type;

   // Clamp a request total to the count range
   function automatic count_type clamp_total(input logic [TOTAL_W-1:0] t);
      logic [WIDE_W-1:0] v;
      v = WIDE_W'(t);
      if (v > WIDE_W'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return COUNT_WIDTH'(v);
   endfunction

   // Saturating increment
   function automatic count_type bump(input count_type v);
      if (v == COUNT_MAX) begin
         return v;
      end
      return v + COUNT_ONE;
   endfunction

   // Count to the 15-bit arrival field, saturating
   function automatic logic [ARR_W-1:0] arrival_sat(input count_type v);
      if (WIDE_W'(v) > ARR_MAX_W) begin
         return '1;
      end
      return ARR_W'(v);
   endfunction

   // target minus prior, saturated to the signed 16-bit field
   function automatic logic signed [REM_W-1:0] rem_sat(input count_type mx,
                                                       input count_type pr);
      logic signed [WIDE_W-1:0] d;
      d = $signed(WIDE_W'(mx)) - $signed(WIDE_W'(pr));
      if (d > REM_HI_W) begin
         d = REM_HI_W;
      end else if (d < REM_LO_W) begin
         d = REM_LO_W;
      end
      return REM_W'(d);
   endfunction

endpackage

/* src/tsct_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module tsct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tsct_slot_map.sv */
// Slot map: busy flag and written flag per slot, plus the registered
// search for the lowest free slot at or above the reserved base.
// Depends on tsct_pkg.
module tsct_slot_map (
   input  logic                   clock,
   input  logic                   reset,
   input  tsct_pkg::slot_upd_type upd,
   input  tsct_pkg::slot_type     q_idx,
   output logic                   q_busy,
   output logic                   q_written,
   output tsct_pkg::free_info_type free_info
);
   import tsct_pkg::*;

   logic [NUM_SLOTS-1:0] busy_ff;
   logic [NUM_SLOTS-1:0] busy_in;
   logic [NUM_SLOTS-1:0] written_ff;
   logic [NUM_SLOTS-1:0] written_in;
   free_info_type        free_ff;
   free_info_type        free_in;

   // Flag updates; any entry write marks the entry as written
   always_comb begin
      busy_in    = busy_ff;
      written_in = written_ff;
      if (upd.en) begin
         busy_in[upd.idx]    = upd.busy;
         written_in[upd.idx] = 1'b1;
      end
   end

   // Priority search, lowest index wins
   always_comb begin
      free_in = '0;
      for (int s = NUM_SLOTS - 1; s >= FIRST_SLOT; s--) begin
         if (!busy_ff[s]) begin
            free_in.found = 1'b1;
            free_in.slot  = SLOT_W'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= '0;
         written_ff <= '0;
         free_ff    <= '0;
      end else begin
         busy_ff    <= busy_in;
         written_ff <= written_in;
         free_ff    <= free_in;
      end
   end

   assign q_busy    = busy_ff[q_idx];
   assign q_written = written_ff[q_idx];
   assign free_info = free_ff;

endmodule

/* src/task_slot_completion_table.sv */
// Task slot completion table, top level: request capture, sequencer,
// read-modify-write datapath and result register.
// Depends on tsct_pkg, tsct_ram and tsct_slot_map.
//
// Usage: a request beat arrives on req_* (valid/stall) and produces exactly
// one result beat on rsp_*. Register claims the lowest free slot at or
// above the reserved base; arrival bumps a slot's tasker count; last query
// compares a given count with the tasker target; worker done bumps the
// worker count and frees the slot on the final worker.
// Timing: the slot entry is read from the registered-read RAM on the accept
// edge and written back when the result is loaded into the result register,
// which waits while a held result is stalled. A new request is taken only
// after the previous one is written back. The next write-back follows any
// earlier one, so no forwarding is needed.
// Reset: all slots free, all counts zero (per-slot written flags make
// unwritten entries read as zero). No clearing pass is needed.
// A stalled result holds in the result register; one further request is
// accepted and waits, read done, until the result register frees up.
module task_slot_completion_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tsct_pkg::TYPE_W-1:0]    req_type,
   input  logic [tsct_pkg::ORIGIN_W-1:0]  req_origin_code,
   input  logic [tsct_pkg::KIND_W-1:0]    req_task_kind,
   input  logic [tsct_pkg::TOTAL_W-1:0]   req_worker_total,
   input  logic [tsct_pkg::TOTAL_W-1:0]   req_tasker_total,
   input  logic [tsct_pkg::IDX_IN_W-1:0]  req_slot_index,
   input  logic [tsct_pkg::TOTAL_W-1:0]   req_stored_count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tsct_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tsct_pkg::GRANT_W-1:0]   rsp_granted_slot,
   output logic [tsct_pkg::ARR_W-1:0]     rsp_arrival_count,
   output logic                           rsp_is_last,
   output logic signed [tsct_pkg::REM_W-1:0] rsp_remaining
);
   import tsct_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;
   logic    accept;
   logic    exec_go;

   // Captured request
   logic [TYPE_W-1:0]   type_ff;
   logic [ORIGIN_W-1:0] origin_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [TOTAL_W-1:0]  wtot_ff;
   logic [TOTAL_W-1:0]  ttot_ff;
   logic [IDX_IN_W-1:0] idx_ff;
   logic [TOTAL_W-1:0]  stored_ff;

   // RAM and slot map
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               ram_wr_en;
   slot_type           ram_wr_addr;
   entry_type          wr_entry;
   slot_type           slot_addr;
   logic               q_busy;
   logic               q_written;
   free_info_type      free_info;
   slot_upd_type       upd;
   entry_type          cur;
   logic               out_of_range;

   // Result register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               status_ff;
   status_type               status_in;
   logic [GRANT_W-1:0]       granted_ff;
   logic [GRANT_W-1:0]       granted_in;
   logic [ARR_W-1:0]         arr_ff;
   logic [ARR_W-1:0]         arr_in;
   logic                     last_ff;
   logic                     last_in;
   logic signed [REM_W-1:0]  rem_ff;
   logic signed [REM_W-1:0]  rem_in;

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (exec_go) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      exec_go   = 1'b0;
      unique case (state_ff)
         FSM_IDLE: req_stall = 1'b0;
         FSM_EXEC: exec_go   = !rsp_valid_ff || !rsp_stall;
         default:  req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff   <= req_type;
         origin_ff <= req_origin_code;
         kind_ff   <= req_task_kind;
         wtot_ff   <= req_worker_total;
         ttot_ff   <= req_tasker_total;
         idx_ff    <= req_slot_index;
         stored_ff <= req_stored_count;
      end
   end

   tsct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (SLOT_W'(req_slot_index)),
      .rd_data (ram_rd_data)
   );

   assign slot_addr = SLOT_W'(idx_ff);

   tsct_slot_map u_slot_map (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .q_idx     (slot_addr),
      .q_busy    (q_busy),
      .q_written (q_written),
      .free_info (free_info)
   );

   // Never-written entries read as the reset value
   assign cur          = q_written ? entry_type'(ram_rd_data) : '0;
   assign out_of_range = 32'(idx_ff) >= 32'(NUM_SLOTS);

   // Request execution and write-back
   always_comb begin
      status_in   = STS_OK;
      granted_in  = '0;
      arr_in      = '0;
      last_in     = 1'b0;
      rem_in      = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_addr;
      wr_entry    = cur;
      upd         = '0;
      upd.idx     = slot_addr;
      if (req_op_type'(type_ff) == RQ_REGISTER) begin
         if (origin_ff == ORIGIN_OTHER) begin
            status_in = STS_BAD_ORIGIN;
         end else if (!free_info.found) begin
            status_in = STS_NO_FREE;
         end else if (kind_ff > KIND_WHOLE) begin
            status_in = STS_BAD_KIND;
         end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = free_info.slot;
            wr_entry    = '0;
            if (kind_ff == KIND_SINGLE) begin
               wr_entry.worker_target = COUNT_ONE;
               wr_entry.tasker_target = COUNT_ONE;
            end else begin
               wr_entry.worker_target = clamp_total(wtot_ff);
               wr_entry.tasker_target = clamp_total(ttot_ff);
            end
            upd.en     = 1'b1;
            upd.idx    = free_info.slot;
            upd.busy   = 1'b1;
            granted_in = GRANT_W'(free_info.slot);
         end
      end else if (out_of_range) begin
         status_in = STS_NOT_IN_USE;
      end else begin
         unique case (req_op_type'(type_ff))
            RQ_ARRIVAL: begin
               wr_entry.tasker_done = bump(cur.tasker_done);
               ram_wr_en = 1'b1;
               upd.en    = 1'b1;
               upd.busy  = q_busy;
               arr_in    = arrival_sat(wr_entry.tasker_done);
            end
            RQ_LAST: begin
               last_in = WIDE_W'(stored_ff) == WIDE_W'(cur.tasker_target);
            end
            RQ_DONE: begin
               if (!q_busy) begin
                  status_in = STS_NOT_IN_USE;
               end else begin
                  ram_wr_en = 1'b1;
                  upd.en    = 1'b1;
                  if (cur.worker_target != '0 &&
                      cur.worker_done == cur.worker_target - COUNT_ONE) begin
                     // final worker: free the slot
                     wr_entry = '0;
                     upd.busy = 1'b0;
                  end else begin
                     wr_entry.worker_done = bump(cur.worker_done);
                     upd.busy = 1'b1;
                     rem_in   = rem_sat(cur.worker_target, cur.worker_done);
                  end
               end
            end
            default: status_in = STS_OK;
         endcase
      end
      if (!exec_go) begin
         ram_wr_en = 1'b0;
         upd.en    = 1'b0;
      end
   end

   // Result register
   always_comb begin
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         arr_ff     <= arr_in;
         last_ff    <= last_in;
         rem_ff     <= rem_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_slot  = granted_ff;
   assign rsp_arrival_count = arr_ff;
   assign rsp_is_last       = last_ff;
   assign rsp_remaining     = rem_ff;

endmodule

/* src/tsct_checker.sv */
// Port-level checker for the task slot completion table, bound to the top.
// Depends on tsct_pkg.
module tsct_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [tsct_pkg::STATUS_W-1:0]  rsp_status,
   input logic [tsct_pkg::GRANT_W-1:0]   rsp_granted_slot,
   input logic                           rsp_is_last,
   input logic signed [tsct_pkg::REM_W-1:0] rsp_remaining
);
   import tsct_pkg::*;

   // One request in flight: the beat after an accept is stalled
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one still executing");

   // With no result pending at accept, the result shows after the execute state
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |-> ##2 rsp_valid)
      else $error("result missing two cycles after accept");

   // A failed request carries no grant, no last flag and no remainder
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |->
         rsp_granted_slot == '0 && !rsp_is_last && rsp_remaining == '0)
      else $error("rejected request carries result data");

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_slot) && $stable(rsp_remaining))
      else $error("stalled result beat changed");

endmodule

bind task_slot_completion_table tsct_checker u_tsct_checker (.*);
